// File: design/sff_pkg.sv
// Package: shared types and constants of the stateful flow firewall.
`timescale 1ns / 1ps
package sff_pkg;

  localparam int unsigned TableCapacity = 1024;

  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [15:0] EthHdrEnd     = 16'd14;
  localparam logic [15:0] IpHdrEnd      = 16'd34;
  localparam logic [15:0] L4HdrEnd      = 16'd42;

  localparam logic [7:0] OutsidePortReset = 8'd7;
  localparam logic [7:0] InsidePortReset  = 8'd6;

  localparam logic [7:0] RegOutsidePort = 8'd0;
  localparam logic [7:0] RegInsidePort  = 8'd1;

  typedef struct packed {
    logic [7:0]  ingress_port;
    logic [15:0] frame_len;
    logic [15:0] eth_type;
    logic [7:0]  l4_proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_l4_port;
    logic [15:0] dst_l4_port;
  } in_item_t;

  typedef struct packed {
    logic       verdict;
    logic [7:0] egress_port;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] addr_lo;
    logic [31:0] addr_hi;
    logic [15:0] port_lo;
    logic [15:0] port_hi;
  } flow_key_t;

  typedef struct packed {
    logic      drop;
    logic      from_outside;
    flow_key_t key;
  } job_t;

  typedef struct packed {
    logic [7:0] outside_port;
    logic [7:0] inside_port;
  } cfg_t;

endpackage

// File: design/sff_front.sv
// Front end: header checks and direction-free flow key.
`timescale 1ns / 1ps
module sff_front (
  input  sff_pkg::in_item_t item_i,
  input  sff_pkg::cfg_t     cfg_i,
  output sff_pkg::job_t     job_o
);
  import sff_pkg::*;

  logic short_frame;
  logic bad_type;
  logic bad_proto;

  assign short_frame = (item_i.frame_len < EthHdrEnd) || (item_i.frame_len < IpHdrEnd) ||
                       (item_i.frame_len < L4HdrEnd);
  assign bad_type    = item_i.eth_type != EthertypeIpv4;
  assign bad_proto   = (item_i.l4_proto != ProtoTcp) && (item_i.l4_proto != ProtoUdp);

  always_comb begin
    job_o.drop         = short_frame || bad_type || bad_proto;
    job_o.from_outside = item_i.ingress_port == cfg_i.outside_port;
    job_o.key.proto    = item_i.l4_proto;
    if (item_i.src_addr < item_i.dst_addr) begin
      job_o.key.addr_lo = item_i.src_addr;
      job_o.key.addr_hi = item_i.dst_addr;
    end else begin
      job_o.key.addr_lo = item_i.dst_addr;
      job_o.key.addr_hi = item_i.src_addr;
    end
    if (item_i.src_l4_port < item_i.dst_l4_port) begin
      job_o.key.port_lo = item_i.src_l4_port;
      job_o.key.port_hi = item_i.dst_l4_port;
    end else begin
      job_o.key.port_lo = item_i.dst_l4_port;
      job_o.key.port_hi = item_i.src_l4_port;
    end
  end

endmodule

// File: design/sff_queue.sv
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps
module sff_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sff_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output sff_pkg::job_t job_o,
  output logic          empty_o
);
  import sff_pkg::*;

  job_t       buf_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = buf_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= job_i;
    end
  end

endmodule

// File: design/sff_back.sv
// Back end: hashed flow table with linear probing, insert and verdict.
`timescale 1ns / 1ps
module sff_back #(
  parameter int unsigned Cap = sff_pkg::TableCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sff_pkg::cfg_t      cfg_i,
  input  sff_pkg::job_t      job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output sff_pkg::out_item_t out_o,
  output logic               out_empty_o,
  input  logic               out_pop_i,
  output logic               clearing_o,
  output logic [$clog2(Cap+1)-1:0] count_o
);
  import sff_pkg::*;

  localparam int unsigned IDX_W = $clog2(Cap);
  localparam int unsigned CNT_W = $clog2(Cap + 1);
  localparam int unsigned KEY_W = $bits(flow_key_t);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(Cap - 1);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_CMP  = 2'd3;

  function automatic logic [IDX_W-1:0] hash_idx(input flow_key_t k);
    logic [IDX_W-1:0] h;
    logic [KEY_W-1:0] v;
    v = k;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ v[i];
    end
    if (CNT_W'(h) >= CNT_W'(Cap)) begin
      h = h - IDX_W'(Cap);
    end
    return h;
  endfunction

  logic [KEY_W:0]   mem [Cap];
  logic [KEY_W:0]   rdata_q;
  logic             mem_we;
  logic [KEY_W:0]   mem_wd;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0] nprobe_q, nprobe_d;
  logic [CNT_W-1:0] count_q, count_d;
  job_t             job_q, job_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             hit, slot_free;
  logic [IDX_W-1:0] addr_next;

  assign hit         = rdata_q[KEY_W] && (rdata_q[KEY_W-1:0] == job_q.key);
  assign slot_free   = !rdata_q[KEY_W];
  assign addr_next   = (addr_q == LastIdx) ? '0 : addr_q + IDX_W'(1);
  assign out_empty_o = !out_valid_q;
  assign out_o       = out_q;
  assign clearing_o  = state_q == S_CLR;
  assign count_o     = count_q;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    nprobe_d    = nprobe_q;
    count_d     = count_q;
    job_d       = job_q;
    out_valid_d = out_valid_q && !out_pop_i;
    out_d       = out_q;
    job_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_wd      = '0;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        addr_d = addr_next;
        if (addr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!job_empty_i && !out_valid_q) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          if (job_i.drop) begin
            out_valid_d = 1'b1;
            out_d       = '0;
          end else begin
            addr_d   = hash_idx(job_i.key);
            nprobe_d = '0;
            state_d  = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit || slot_free || (nprobe_q == CNT_W'(Cap - 1))) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          if (job_q.from_outside) begin
            out_d.verdict     = hit;
            out_d.egress_port = hit ? cfg_i.inside_port : 8'd0;
          end else begin
            out_d.verdict     = 1'b1;
            out_d.egress_port = cfg_i.outside_port;
            if (!hit && slot_free && (count_q < CNT_W'(Cap))) begin
              mem_we  = 1'b1;
              mem_wd  = {1'b1, job_q.key};
              count_d = count_q + CNT_W'(1);
            end
          end
        end else begin
          addr_d   = addr_next;
          nprobe_d = nprobe_q + CNT_W'(1);
          state_d  = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      addr_q      <= '0;
      nprobe_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      nprobe_q    <= nprobe_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wd;
    end
    rdata_q <= mem[addr_q];
  end

endmodule

// File: design/stateful_flow_firewall.sv
// Top level: stateful flow firewall with direction-free connection tracking.
`timescale 1ns / 1ps
// Takes one parsed header per item and returns one verdict per item, in order.
// After reset the flow table of Cap entries (1024 by default) is swept clear;
// items are queued but no verdict leaves until the sweep ends. A dropped item
// is answered from the idle state without a table lookup; a table lookup reads
// and then compares each probe slot of the single-port table memory in turn.
// Items are held in a two-entry queue between the header checks and the table
// engine, so up to two items are taken while a verdict waits to be popped.
module stateful_flow_firewall #(
  parameter int unsigned Cap = sff_pkg::TableCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  sff_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output sff_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);
  import sff_pkg::*;

  cfg_t cfg_q;
  job_t front_job, queue_job;
  logic queue_empty, queue_pop, clearing;
  logic [$clog2(Cap+1)-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outside_port <= OutsidePortReset;
      cfg_q.inside_port  <= InsidePortReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegOutsidePort) begin
        cfg_q.outside_port <= cfg_data_i;
      end else if (cfg_idx_i == RegInsidePort) begin
        cfg_q.inside_port <= cfg_data_i;
      end
    end
  end

  sff_front u_front (
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .job_o  (front_job)
  );

  sff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (queue_pop),
    .job_o   (queue_job),
    .empty_o (queue_empty)
  );

  sff_back #(.Cap(Cap)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (queue_job),
    .job_empty_i (queue_empty),
    .job_pop_o   (queue_pop),
    .out_o       (out_item_o),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .clearing_o  (clearing),
    .count_o     (count)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= ($clog2(Cap+1))'(Cap)) else $error("flow count above capacity");

  a_no_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> empty) else $error("verdict during table clear");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.verdict) |-> (out_item_o.egress_port == 8'd0))
    else $error("drop with nonzero egress port");

  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !queue_pop) else $error("item taken during table clear");

endmodule
